// ===== hdl/afdc_pkg.sv =====
// ----------------------------------------------------------------------------
// afdc_pkg
// shared types and constants of the affine displacement field compose block
// ----------------------------------------------------------------------------
package afdc_pkg;

    localparam int DATA_W    = 32;
    localparam int COORD_W   = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PC_W      = DATA_W + COORD_W + 1;
    localparam int SUM_W     = 2 * DATA_W + 2;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int SIZE_W    = 48;
    localparam int TDATA_W   = 3 * DATA_W;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SIZE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_D     = 3'd7;

    // coefficients indexed [row][column], translation indexed [row]
    typedef struct packed {
        logic [2:0][2:0][DATA_W-1:0] coef;
        logic [2:0][DATA_W-1:0]      trans;
        logic                        three_d;
    } t_cfg;

    // one voxel as it waits between front and back
    typedef struct packed {
        logic [2:0][DATA_W-1:0]  disp;
        logic [2:0][COORD_W-1:0] coord;
        logic                    last;
    } t_item;

endpackage

// ===== hdl/afdc_front.sv =====
// ----------------------------------------------------------------------------
// afdc_front
// voxel counters: tags each accepted item with its coordinate and end flag
// ----------------------------------------------------------------------------
module afdc_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [afdc_pkg::SIZE_W-1:0]  i_size,
    input  logic                         i_push,
    input  logic [afdc_pkg::TDATA_W-1:0] i_data,
    output afdc_pkg::t_item              o_item
);

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] r_slice;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;
    logic [COORD_BITS-1:0] n_slice;
    logic [COORD_BITS-1:0] w_size_x;
    logic [COORD_BITS-1:0] w_size_y;
    logic [COORD_BITS-1:0] w_size_z;
    logic                  w_last_x;
    logic                  w_last_y;
    logic                  w_last_z;

    assign w_size_x = i_size[COORD_BITS-1:0];
    assign w_size_y = i_size[16 +: COORD_BITS];
    assign w_size_z = i_size[32 +: COORD_BITS];

    assign w_last_x = r_col >= w_size_x;
    assign w_last_y = r_row >= w_size_y;
    assign w_last_z = r_slice >= w_size_z;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_slice = r_slice;
        if (!w_last_x) begin
            n_col = COORD_BITS'(r_col + 1'b1);
        end else begin
            n_col = '0;
            if (!w_last_y) begin
                n_row = COORD_BITS'(r_row + 1'b1);
            end else begin
                n_row   = '0;
                n_slice = w_last_z ? '0 : COORD_BITS'(r_slice + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
        end else if (i_push) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_slice <= n_slice;
        end
    end

    always_comb begin
        o_item.disp[0]  = i_data[0 +: afdc_pkg::DATA_W];
        o_item.disp[1]  = i_data[afdc_pkg::DATA_W +: afdc_pkg::DATA_W];
        o_item.disp[2]  = i_data[2*afdc_pkg::DATA_W +: afdc_pkg::DATA_W];
        o_item.coord[0] = afdc_pkg::COORD_W'(r_col);
        o_item.coord[1] = afdc_pkg::COORD_W'(r_row);
        o_item.coord[2] = afdc_pkg::COORD_W'(r_slice);
        o_item.last     = w_last_x && w_last_y && w_last_z;
    end

endmodule

// ===== hdl/afdc_queue.sv =====
// ----------------------------------------------------------------------------
// afdc_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module afdc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  afdc_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output afdc_pkg::t_item o_item
);

    afdc_pkg::t_item                 r_mem [afdc_pkg::Q_DEPTH];
    logic [afdc_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [afdc_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [afdc_pkg::Q_CNT_W-1:0]    r_count;

    assign o_ready = r_count != afdc_pkg::Q_CNT_W'(afdc_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= afdc_pkg::Q_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= afdc_pkg::Q_PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= afdc_pkg::Q_CNT_W'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= afdc_pkg::Q_CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

// ===== hdl/afdc_back.sv =====
// ----------------------------------------------------------------------------
// afdc_back
// three-stage affine pipeline: products, floored terms, row sums with saturation
// ----------------------------------------------------------------------------
module afdc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  afdc_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    input  afdc_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [afdc_pkg::TDATA_W-1:0] o_data,
    output logic                         o_last
);

    localparam int SUM_W = afdc_pkg::SUM_W;

    logic                                   r1_valid;
    logic signed [afdc_pkg::PC_W-1:0]       r1_pc [3][3];
    logic signed [afdc_pkg::PROD_W-1:0]     r1_pd [3][3];
    logic [afdc_pkg::COORD_W-1:0]           r1_coord [3];
    logic                                   r1_last;

    logic                                   r2_valid;
    logic signed [SUM_W-1:0]                r2_term [3][3];
    logic signed [SUM_W-1:0]                r2_adj [3];
    logic                                   r2_last;

    logic                                   r3_valid;
    logic [afdc_pkg::TDATA_W-1:0]           r3_data;
    logic                                   r3_last;

    logic                                   w_en1;
    logic                                   w_en2;
    logic                                   w_en3;
    logic signed [SUM_W-1:0]                w_sum [3];
    logic [afdc_pkg::DATA_W-1:0]            w_sat [3];

    assign w_en3 = !r3_valid || i_ready;
    assign w_en2 = !r2_valid || w_en3;
    assign w_en1 = !r1_valid || w_en2;
    assign o_pop = i_valid && w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_valid <= i_valid;
            end
            if (w_en2) begin
                r2_valid <= r1_valid;
            end
            if (w_en3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    // products of coefficients with coordinates and displacements
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_pc[r][c] <= $signed(i_cfg.coef[r][c])
                                   * $signed({1'b0, i_item.coord[c]});
                    r1_pd[r][c] <= $signed(i_cfg.coef[r][c]) * $signed(i_item.disp[c]);
                end
                r1_coord[r] <= i_item.coord[r];
            end
            r1_last <= i_item.last;
        end
    end

    // floor the displacement product and add the exact coordinate product
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (!i_cfg.three_d && c == 2) begin
                        r2_term[r][c] <= '0;
                    end else begin
                        r2_term[r][c] <= SUM_W'(r1_pc[r][c])
                                         + SUM_W'(r1_pd[r][c] >>> FRAC_BITS);
                    end
                end
                r2_adj[r] <= SUM_W'($signed(i_cfg.trans[r]))
                             - (SUM_W'(r1_coord[r]) << FRAC_BITS);
            end
            r2_last <= r1_last;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = r2_term[r][0] + r2_term[r][1] + r2_term[r][2] + r2_adj[r];
            if (w_sum[r][SUM_W-1:afdc_pkg::DATA_W-1] == '0
                || w_sum[r][SUM_W-1:afdc_pkg::DATA_W-1] == '1) begin
                w_sat[r] = w_sum[r][afdc_pkg::DATA_W-1:0];
            end else if (w_sum[r][SUM_W-1]) begin
                w_sat[r] = {1'b1, {(afdc_pkg::DATA_W-1){1'b0}}};
            end else begin
                w_sat[r] = {1'b0, {(afdc_pkg::DATA_W-1){1'b1}}};
            end
        end
        if (!i_cfg.three_d) begin
            w_sat[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_data <= {w_sat[2], w_sat[1], w_sat[0]};
            r3_last <= r2_last;
        end
    end

    assign o_valid = r3_valid;
    assign o_data  = r3_data;
    assign o_last  = r3_last;

endmodule

// ===== hdl/affine_displacement_field_compose_top.sv =====
// ----------------------------------------------------------------------------
// affine_displacement_field_compose_top
// composes a raster-order displacement field with a 3x4 affine matrix in
// signed fixed point, saturating each component to 32 bits
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s stream  in   i_s_tvalid/o_s_tready   i_s_tdata: disp_x, disp_y, disp_z
//  m stream  out  o_m_tvalid/i_m_tready   o_m_tdata: new_x, new_y, new_z; tlast
//  config    in   i_cfg_we                i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while the output is not stalled; a result is
//  offered once its item has passed the queue entry and the three multiply
//  and sum stages behind it
//  reset clears the voxel counters and loads the identity matrix, size zero
//  and 3d mode
//  a stalled output fills the pipeline, then the queue; o_s_tready drops
//  only when the queue is full
// ----------------------------------------------------------------------------
module affine_displacement_field_compose_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [afdc_pkg::TDATA_W-1:0]   i_s_tdata,   // disp_x, disp_y, disp_z
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [afdc_pkg::TDATA_W-1:0]   o_m_tdata,   // new_x, new_y, new_z
    output logic                           o_m_tlast,   // volume_end
    input  logic                           i_cfg_we,
    input  logic [afdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [afdc_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [afdc_pkg::CFG_W-1:0]  r_row0_first;
    logic [afdc_pkg::CFG_W-1:0]  r_row0_second;
    logic [afdc_pkg::CFG_W-1:0]  r_row1_first;
    logic [afdc_pkg::CFG_W-1:0]  r_row1_second;
    logic [afdc_pkg::CFG_W-1:0]  r_row2_first;
    logic [afdc_pkg::CFG_W-1:0]  r_row2_second;
    logic [afdc_pkg::SIZE_W-1:0] r_volume_size;
    logic                        r_three_d;

    afdc_pkg::t_cfg  w_cfg;
    afdc_pkg::t_item w_push_item;
    afdc_pkg::t_item w_head_item;
    logic            w_push;
    logic            w_q_ready;
    logic            w_q_valid;
    logic            w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_first  <= 64'h0001_0000_0000_0000;
            r_row0_second <= '0;
            r_row1_first  <= 64'h0000_0000_0001_0000;
            r_row1_second <= '0;
            r_row2_first  <= '0;
            r_row2_second <= 64'h0001_0000_0000_0000;
            r_volume_size <= '0;
            r_three_d     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afdc_pkg::CFG_ROW0_FIRST:  r_row0_first  <= i_cfg_data;
                afdc_pkg::CFG_ROW0_SECOND: r_row0_second <= i_cfg_data;
                afdc_pkg::CFG_ROW1_FIRST:  r_row1_first  <= i_cfg_data;
                afdc_pkg::CFG_ROW1_SECOND: r_row1_second <= i_cfg_data;
                afdc_pkg::CFG_ROW2_FIRST:  r_row2_first  <= i_cfg_data;
                afdc_pkg::CFG_ROW2_SECOND: r_row2_second <= i_cfg_data;
                afdc_pkg::CFG_VOLUME_SIZE: r_volume_size <= i_cfg_data[afdc_pkg::SIZE_W-1:0];
                afdc_pkg::CFG_THREE_D:     r_three_d     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg.coef[0][0] = r_row0_first[63:32];
        w_cfg.coef[0][1] = r_row0_first[31:0];
        w_cfg.coef[0][2] = r_row0_second[63:32];
        w_cfg.coef[1][0] = r_row1_first[63:32];
        w_cfg.coef[1][1] = r_row1_first[31:0];
        w_cfg.coef[1][2] = r_row1_second[63:32];
        w_cfg.coef[2][0] = r_row2_first[63:32];
        w_cfg.coef[2][1] = r_row2_first[31:0];
        w_cfg.coef[2][2] = r_row2_second[63:32];
        w_cfg.trans[0]   = r_row0_second[31:0];
        w_cfg.trans[1]   = r_row1_second[31:0];
        w_cfg.trans[2]   = r_row2_second[31:0];
        w_cfg.three_d    = r_three_d;
    end

    assign o_s_tready = w_q_ready;
    assign w_push     = i_s_tvalid && w_q_ready;

    afdc_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (r_volume_size),
        .i_push  (w_push),
        .i_data  (i_s_tdata),
        .o_item  (w_push_item)
    );

    afdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    afdc_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_q_valid),
        .i_item  (w_head_item),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    // after the last voxel the counters restart at the origin
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_push_item.last |=> (w_push_item.coord == '0))
        else $error("counters did not return to origin after volume end");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_two_d_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !r_three_d |-> (o_m_tdata[95:64] == '0))
        else $error("nonzero z result in 2d mode");

    a_pop_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue read while empty");

endmodule
